FILE: hw/rtl/decimal_digit_extractor_unit_assert.svh
// ----------------------------------------------------------------------------
// decimal digit extractor assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef DECIMAL_DIGIT_EXTRACTOR_UNIT_ASSERT_SVH
`define DECIMAL_DIGIT_EXTRACTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define DDE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dde same-cycle check failed");

// next-cycle implication
`define DDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dde next-cycle check failed");

`endif

FILE: hw/rtl/dde_pkg.sv
// ----------------------------------------------------------------------------
// dde_pkg
// shared types, constants and elaboration helpers of the digit extractor
// ----------------------------------------------------------------------------
package dde_pkg;

    localparam int VALUE_W     = 40;
    localparam int POS_W       = 5;
    localparam int DIGIT_W     = 4;
    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_TUSER_W = 1;

    localparam int DEF_INT_BITS        = 24;
    localparam int DEF_FRAC_BITS       = 16;
    localparam int DEF_MAX_FRAC_DIGITS = 4;

    // decimal digits needed for any value below 2^bits
    function automatic int dec_digits(input int bits);
        return (bits * 30103) / 100000 + 1;
    endfunction

    // binary bits needed to hold 10^n
    function automatic int pow10_bits(input int n);
        return (n * 332193) / 100000 + 1;
    endfunction

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    typedef enum logic [1:0] {
        KIND_SIGN,
        KIND_ZERO,
        KIND_FRAC,
        KIND_INT
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MUL,
        ST_CONV_LOAD,
        ST_CONV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic conv_start;
        logic conv_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  cnt_last;
    } status_t;

endpackage

FILE: hw/rtl/decimal_digit_extractor_unit.sv
// ----------------------------------------------------------------------------
// decimal_digit_extractor_unit
// picks one decimal digit, or the sign, out of a signed fixed-point value
// ----------------------------------------------------------------------------
// One transaction in, one digit out. The value is a two's complement
// fixed-point number with INT_BITS integer and FRAC_BITS fraction bits; a
// sign query returns 1 for negative. Positions 0 and up select a digit of
// the truncated integer magnitude, optionally flagged absent as a hidden
// leading zero; negative positions select a digit of the magnitude scaled by
// 10^-position and rounded half away from zero, and positions finer than
// MAX_FRAC_DIGITS read as 0. Work is one item at a time: a sign query or an
// out-of-range fraction position goes from dispatch straight to finish; an
// integer digit runs through the bit-serial shift-add-3 bcd converter, one
// bit per cycle over CONV_BITS = max(INT_BITS, bits of 10^MAX_FRAC_DIGITS
// + 1) bits, and a fraction digit is first scaled by one multiply-by-ten per
// fraction place before the same conversion. The result sits in an output
// register, so the next transaction is taken while the previous digit still
// waits for tready.
module decimal_digit_extractor_unit #(
    parameter int INT_BITS        = dde_pkg::DEF_INT_BITS,
    parameter int FRAC_BITS       = dde_pkg::DEF_FRAC_BITS,
    parameter int MAX_FRAC_DIGITS = dde_pkg::DEF_MAX_FRAC_DIGITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // value [39:0], position [44:40], zero pad [47:45]
    input  logic [dde_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // ask_sign [0], hide_leading_zeros [1]
    input  logic [dde_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // digit [3:0], zero pad [7:4]
    output logic [dde_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // digit_absent [0]
    output logic [dde_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);
    import dde_pkg::*;

    cmd_t               cmd;
    status_t            status;
    logic [DIGIT_W-1:0] digit;
    logic               digit_absent;

    // datapath: scaling, bcd conversion, digit select and output register
    dde_datapath #(
        .INT_BITS        (INT_BITS),
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .value              (s_axis_tdata[VALUE_W-1:0]),
        .ask_sign           (s_axis_tuser[0]),
        .position           (s_axis_tdata[VALUE_W +: POS_W]),
        .hide_leading_zeros (s_axis_tuser[1]),
        .cmd                (cmd),
        .status             (status),
        .digit              (digit),
        .digit_absent       (digit_absent)
    );

    // controller: handshakes and step sequencing
    dde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    assign m_axis_tdata = OUT_TDATA_W'(digit);
    assign m_axis_tuser = OUT_TUSER_W'(digit_absent);

endmodule

FILE: hw/rtl/dde_datapath.sv
// ----------------------------------------------------------------------------
// dde_datapath
// magnitude, fraction scaling by ten, shift-add-3 bcd converter, digit select
// ----------------------------------------------------------------------------
module dde_datapath #(
    parameter int INT_BITS        = dde_pkg::DEF_INT_BITS,
    parameter int FRAC_BITS       = dde_pkg::DEF_FRAC_BITS,
    parameter int MAX_FRAC_DIGITS = dde_pkg::DEF_MAX_FRAC_DIGITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [dde_pkg::VALUE_W-1:0]    value,
    input  logic                           ask_sign,
    input  logic [dde_pkg::POS_W-1:0]      position,
    input  logic                           hide_leading_zeros,
    input  dde_pkg::cmd_t                  cmd,
    output dde_pkg::status_t               status,
    output logic [dde_pkg::DIGIT_W-1:0]    digit,
    output logic                           digit_absent
);
    import dde_pkg::*;

    localparam int TOTAL_BITS = INT_BITS + FRAC_BITS;
    localparam int RB         = pow10_bits(MAX_FRAC_DIGITS);
    localparam int PROD_W     = FRAC_BITS + RB + 1;
    localparam int CONV_BITS  = max_int(INT_BITS, RB + 1);
    localparam int ND         = dec_digits(CONV_BITS);
    localparam int CNT_W      = $clog2(max_int(CONV_BITS, 16) + 1);

    logic [TOTAL_BITS-1:0] v;
    logic [TOTAL_BITS-1:0] mag;
    logic [POS_W-1:0]      p_in;

    generate
        if (TOTAL_BITS <= VALUE_W) begin : g_narrow
            assign v = value[TOTAL_BITS-1:0];
        end
        else begin : g_wide
            assign v = {{(TOTAL_BITS-VALUE_W){value[VALUE_W-1]}}, value};
        end
    endgenerate

    // two's complement magnitude; most negative value reads as 2^(TOTAL_BITS-1)
    assign mag  = v[TOTAL_BITS-1] ? (~v + TOTAL_BITS'(1)) : v;
    assign p_in = ~position + POS_W'(1);

    logic                 neg_reg, ask_reg, hide_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [INT_BITS-1:0]  ip_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [CONV_BITS-1:0] bin_reg;
    logic [ND*4-1:0]      bcd_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIGIT_W-1:0]   digit_reg;
    logic                 absent_reg;

    logic [POS_W-1:0]     p_reg;
    logic [PROD_W-1:0]    round_sum;
    logic [RB:0]          rounded;
    logic [ND*4-1:0]      bcd_adj;
    logic [ND*4-1:0]      bcd_shift;
    logic [CONV_BITS-1:0] bin_shift;
    kind_t                kind;
    logic [DIGIT_W-1:0]   digit_sel;
    logic                 absent_sel;
    logic [DIGIT_W-1:0]   int_digit;
    logic                 nz_hi;

    assign p_reg     = ~pos_reg + POS_W'(1);
    assign round_sum = prod_reg + (PROD_W'(1) << (FRAC_BITS - 1));
    assign rounded   = round_sum[PROD_W-1:FRAC_BITS];

    always_comb
    begin
        if (ask_reg)
            kind = KIND_SIGN;
        else if (pos_reg[POS_W-1])
            kind = (p_reg > POS_W'(MAX_FRAC_DIGITS)) ? KIND_ZERO : KIND_FRAC;
        else
            kind = KIND_INT;
    end

    assign status.kind     = kind;
    assign status.cnt_last = (cnt_reg == CNT_W'(1));

    // add-3 correction then one shift
    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < ND; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
        end
        bcd_shift = {bcd_adj[ND*4-2:0], bin_reg[CONV_BITS-1]};
        bin_shift = bin_reg << 1;
    end

    always_comb
    begin
        int_digit = '0;
        nz_hi     = 1'b0;
        for (int i = 0; i < ND; i++)
        begin
            if (POS_W'(i) == pos_reg)
                int_digit = bcd_reg[i*4 +: 4];
            if (POS_W'(i) >= pos_reg && bcd_reg[i*4 +: 4] != 4'd0)
                nz_hi = 1'b1;
        end
    end

    always_comb
    begin
        digit_sel  = '0;
        absent_sel = 1'b0;
        unique case (kind)
            KIND_SIGN: digit_sel = DIGIT_W'(neg_reg);
            KIND_ZERO: digit_sel = '0;
            KIND_FRAC: digit_sel = bcd_reg[3:0];
            KIND_INT:
            begin
                if (hide_reg && pos_reg != '0 && !nz_hi)
                    absent_sel = 1'b1;
                else
                    digit_sel = int_digit;
            end
            default: digit_sel = '0;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load)
            cnt_next = position[POS_W-1] ? CNT_W'(p_in) : '0;
        else if (cmd.conv_start)
            cnt_next = CNT_W'(CONV_BITS);
        else if (cmd.mul || cmd.conv_step)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg  <= v[TOTAL_BITS-1];
            ask_reg  <= ask_sign;
            hide_reg <= hide_leading_zeros;
            pos_reg  <= position;
            ip_reg   <= mag[TOTAL_BITS-1:FRAC_BITS];
            prod_reg <= PROD_W'(mag[FRAC_BITS-1:0]);
        end
        else if (cmd.mul)
        begin
            prod_reg <= (prod_reg << 3) + (prod_reg << 1);
        end
        if (cmd.conv_start)
        begin
            bin_reg <= (kind == KIND_INT) ? CONV_BITS'(ip_reg) : CONV_BITS'(rounded);
            bcd_reg <= '0;
        end
        else if (cmd.conv_step)
        begin
            bin_reg <= bin_shift;
            bcd_reg <= bcd_shift;
        end
        if (cmd.out_load)
        begin
            digit_reg  <= digit_sel;
            absent_reg <= absent_sel;
        end
    end

    assign digit        = digit_reg;
    assign digit_absent = absent_reg;

endmodule

FILE: hw/rtl/dde_ctrl.sv
// ----------------------------------------------------------------------------
// dde_ctrl
// sequencer for load, scaling, conversion and output register handoff
// ----------------------------------------------------------------------------
`include "decimal_digit_extractor_unit_assert.svh"

module dde_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  dde_pkg::status_t status,
    output dde_pkg::cmd_t    cmd
);
    import dde_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (status.kind)
                    KIND_SIGN, KIND_ZERO: state_next = ST_FINISH;
                    KIND_FRAC:            state_next = ST_MUL;
                    KIND_INT:             state_next = ST_CONV_LOAD;
                    default:              state_next = ST_FINISH;
                endcase
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                if (status.cnt_last)
                    state_next = ST_CONV_LOAD;
            end
            ST_CONV_LOAD:
            begin
                cmd.conv_start = 1'b1;
                state_next     = ST_CONV;
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (status.cnt_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

    // a waiting result is never overwritten
    `DDE_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_reg || out_ready)
    // a freshly accepted transaction cannot produce a result in the next cycle
    `DDE_ASSERT_NEXT(a_no_early_result, clk, rst_n, in_valid && in_ready, !cmd.out_load)
    // conversion ends right after its last shift
    `DDE_ASSERT_NEXT(a_conv_end, clk, rst_n, state_reg == ST_CONV && status.cnt_last, state_reg == ST_FINISH)

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal digit extractor testbench
// streams digit requests through the unit under random handshake gaps and
// checks every returned digit and absent flag against a local digit predictor
// ----------------------------------------------------------------------------
module testbench;

    localparam int VALUE_W         = dde_pkg::VALUE_W;
    localparam int FRAC_BITS       = dde_pkg::DEF_FRAC_BITS;
    localparam int MAX_FRAC_DIGITS = dde_pkg::DEF_MAX_FRAC_DIGITS;
    localparam int RANDOM_ITEMS    = 1200;
    localparam int QUIET_ITEMS     = 150;   // tail of the run without idling
    localparam int LINGER_CYCLES   = 48;
    localparam int STORE_DEPTH     = 4096;
    localparam int REPORT_LIMIT    = 10;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               ask_sign;
        logic [4:0]         position;
        logic               hide;
        bit                 drain_first;   // hold off until all digits are back
    } digit_req_t;

    typedef struct packed {
        logic [3:0] digit;
        logic       absent;
    } digit_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [dde_pkg::IN_TDATA_W-1:0]    s_axis_tdata = '0;
    logic [dde_pkg::IN_TUSER_W-1:0]    s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [dde_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic [dde_pkg::OUT_TUSER_W-1:0]   m_axis_tuser;

    digit_req_t pending_reqs[$];
    digit_res_t expected_digits [0:STORE_DEPTH-1];
    int         sent_cnt = 0;
    int         recv_cnt = 0;
    int         error_cnt = 0;
    int         gap_left = 0;
    int         stall_left = 0;
    logic       quiet = 1'b0;
    digit_req_t next_req;
    digit_res_t got;

    decimal_digit_extractor_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // sign, digit of the truncated integer magnitude, or rounded scaled fraction
    function automatic digit_res_t predict_digit(input logic [VALUE_W-1:0] value,
                                                 input logic ask_sign,
                                                 input logic [4:0] position,
                                                 input logic hide);
        digit_res_t   res;
        logic         neg;
        logic [VALUE_W-1:0] mag;
        logic [63:0]  int_part;
        logic [63:0]  scale;
        logic [63:0]  prod;
        logic [63:0]  rounded;
        int           pos;
        int           places;
        res = '0;
        neg = value[VALUE_W-1];
        mag = neg ? (~value + 1'b1) : value;
        int_part = 64'(mag) >> FRAC_BITS;
        pos = $signed(position);
        scale = 64'd1;
        if (ask_sign)
            res.digit = {3'b000, neg};
        else if (pos >= 0)
        begin
            for (int i = 0; i < pos; i++)
                scale = scale * 10;
            if (hide && pos > 0 && int_part < scale)
                res.absent = 1'b1;
            else
                res.digit = 4'((int_part / scale) % 10);
        end
        else
        begin
            places = -pos;
            // integer part scaled by a power of ten adds nothing modulo 10
            if (places <= MAX_FRAC_DIGITS)
            begin
                for (int i = 0; i < places; i++)
                    scale = scale * 10;
                prod = 64'(mag[FRAC_BITS-1:0]) * scale;
                rounded = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                res.digit = 4'(rounded % 10);
            end
        end
        return res;
    endfunction

    function automatic logic [VALUE_W-1:0] fixed_of(input int int_part, input int frac,
                                                    input bit negate);
        logic [VALUE_W-1:0] v;
        v = {int_part[23:0], frac[15:0]};
        return negate ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = {8'($urandom), 32'($urandom)};
            1: v = fixed_of($urandom_range(0, 99999), $urandom_range(0, 65535),
                            1'($urandom_range(0, 1)));
            2: v = fixed_of($urandom_range(0, 999), $urandom_range(0, 65535),
                            1'($urandom_range(0, 1)));
            default:
            begin
                case ($urandom_range(0, 2))
                    0: v = fixed_of(0, 0, 0);
                    1: v = fixed_of(8388607, 65535, 0);
                    default: v = fixed_of(8388608, 0, 1);   // most negative
                endcase
                v[$urandom_range(0, VALUE_W-1)] ^= 1'b1;
            end
        endcase
        return v;
    endfunction

    task automatic add_req(input logic [VALUE_W-1:0] value, input logic ask_sign,
                           input int position, input logic hide, input bit drain_first);
        digit_req_t r;
        r.value = value;
        r.ask_sign = ask_sign;
        r.position = position[4:0];
        r.hide = hide;
        r.drain_first = drain_first;
        pending_reqs.push_back(r);
    endtask

    task automatic note_failure(input string msg);
        error_cnt++;
        if (error_cnt <= REPORT_LIMIT)
            $display("mismatch %0d: %s", error_cnt, msg);
    endtask

    // driver: presents queued requests, predicts each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            gap_left      <= 0;
            sent_cnt      <= 0;
            quiet         <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_digits[sent_cnt] = predict_digit(s_axis_tdata[39:0],
                    s_axis_tuser[0], s_axis_tdata[44:40], s_axis_tuser[1]);
                sent_cnt <= sent_cnt + 1;
            end
            quiet <= (pending_reqs.size() <= QUIET_ITEMS);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() == 0)
                    s_axis_tvalid <= 1'b0;
                else if (pending_reqs[0].drain_first &&
                         (sent_cnt != recv_cnt || (s_axis_tvalid && s_axis_tready)))
                    s_axis_tvalid <= 1'b0;
                else if (!quiet && $urandom_range(0, 9) == 0)
                begin
                    gap_left <= $urandom_range(0, 14);
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    next_req = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {3'b000, next_req.position, next_req.value};
                    s_axis_tuser  <= {next_req.hide, next_req.ask_sign};
                end
            end
        end
    end

    // monitor: checks each result transaction against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
            recv_cnt      <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (recv_cnt >= sent_cnt)
                    note_failure($sformatf("unexpected digit %0d absent %0b",
                                           m_axis_tdata[3:0], m_axis_tuser[0]));
                else
                begin
                    got = expected_digits[recv_cnt];
                    if (m_axis_tdata[3:0] !== got.digit)
                        note_failure($sformatf("result %0d digit expected %0d got %0d",
                                               recv_cnt, got.digit, m_axis_tdata[3:0]));
                    if (m_axis_tuser[0] !== got.absent)
                        note_failure($sformatf("result %0d absent expected %0b got %0b",
                                               recv_cnt, got.absent, m_axis_tuser[0]));
                    recv_cnt <= recv_cnt + 1;
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left <= $urandom_range(0, 14);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        // sign queries, position ignored
        add_req(fixed_of(0, 0, 0), 1'b1, 0, 1'b0, 1'b0);
        add_req({VALUE_W{1'b1}}, 1'b1, -1, 1'b0, 1'b0);
        add_req(fixed_of(8388608, 0, 1), 1'b1, 3, 1'b1, 1'b0);
        add_req({1'b0, {(VALUE_W-1){1'b1}}}, 1'b1, 15, 1'b1, 1'b0);
        // most negative magnitude used exactly
        add_req(fixed_of(8388608, 0, 1), 1'b0, 6, 1'b0, 1'b0);
        add_req(fixed_of(8388608, 0, 1), 1'b0, 7, 1'b1, 1'b0);
        add_req({1'b0, {(VALUE_W-1){1'b1}}}, 1'b0, 0, 1'b1, 1'b0);
        add_req({1'b0, {(VALUE_W-1){1'b1}}}, 1'b0, -4, 1'b0, 1'b0);
        // leading zero hiding
        add_req(fixed_of(123456, 51709, 0), 1'b0, 5, 1'b1, 1'b0);
        add_req(fixed_of(123456, 51709, 0), 1'b0, 6, 1'b1, 1'b0);
        add_req(fixed_of(123456, 51709, 0), 1'b0, 6, 1'b0, 1'b0);
        add_req(fixed_of(123456, 51709, 0), 1'b0, 15, 1'b0, 1'b0);
        add_req(fixed_of(123456, 51709, 0), 1'b0, 15, 1'b1, 1'b0);
        add_req(fixed_of(0, 0, 0), 1'b0, 0, 1'b1, 1'b0);
        add_req(fixed_of(0, 0, 0), 1'b0, 1, 1'b1, 1'b0);
        add_req(fixed_of(9, 65535, 0), 1'b0, 1, 1'b1, 1'b0);
        add_req(fixed_of(10, 0, 0), 1'b0, 1, 1'b1, 1'b0);
        // fraction places, beyond precision and rounding carry
        add_req(fixed_of(123456, 51709, 0), 1'b0, -16, 1'b0, 1'b0);
        add_req(fixed_of(123456, 51709, 0), 1'b0, -5, 1'b1, 1'b0);
        add_req(fixed_of(3, 32768, 0), 1'b0, -1, 1'b0, 1'b0);
        add_req(fixed_of(3, 62915, 0), 1'b0, -1, 1'b0, 1'b0);
        add_req(fixed_of(0, 3277, 1), 1'b0, -2, 1'b0, 1'b0);
        add_req(fixed_of(987, 42860, 1), 1'b0, 2, 1'b0, 1'b0);
        add_req(fixed_of(987, 42860, 1), 1'b0, -3, 1'b0, 1'b0);
        add_req(fixed_of(0, 1, 1), 1'b0, -1, 1'b1, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            add_req(rand_value(), ($urandom_range(0, 6) == 0),
                    ($urandom_range(0, 6) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(0, 13) - 4,
                    1'($urandom_range(0, 1)), (n == 0 || n == RANDOM_ITEMS / 2));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || s_axis_tvalid || sent_cnt != recv_cnt)
            @(posedge clk);
        repeat (LINGER_CYCLES) @(posedge clk);

        if (error_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
